### rtl/dpod_pkg.sv
// dpod_pkg: types, constants and calendar helpers for date_period_overlap_days
// no dependencies; imported by rtl/date_period_overlap_days.sv
`default_nettype none

package dpod_pkg;

  localparam int YEAR_W   = 14;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int COUNT_W  = 22;
  // biased year, year + 400 at most
  localparam int BYEAR_W  = 15;
  // quotient of a biased year by 100
  localparam int QUOT_W   = 8;
  localparam int DAYNUM_W = 23;
  localparam int MOFF_W   = 9;
  localparam int PART_W   = 10;
  localparam int NDATES   = 4;

  localparam logic [BYEAR_W-1:0] YEAR_BIAS   = 15'd400;
  // floor(x / 100) == (x * RECIP_100) >> RECIP_SHIFT for x below 43690
  localparam logic [12:0]        RECIP_100   = 13'd5243;
  localparam int                 RECIP_SHIFT = 19;
  localparam logic [6:0]         HUNDRED     = 7'd100;
  localparam logic [8:0]         DAYS_YEAR   = 9'd365;
  localparam logic [COUNT_W-1:0] OVERLAP_MAX = 22'd4194303;

  typedef struct packed {
    logic [YEAR_W-1:0]  first_start_year;
    logic [MONTH_W-1:0] first_start_month;
    logic [DAY_W-1:0]   first_start_day;
    logic [YEAR_W-1:0]  first_end_year;
    logic [MONTH_W-1:0] first_end_month;
    logic [DAY_W-1:0]   first_end_day;
    logic [YEAR_W-1:0]  second_start_year;
    logic [MONTH_W-1:0] second_start_month;
    logic [DAY_W-1:0]   second_start_day;
    logic [YEAR_W-1:0]  second_end_year;
    logic [MONTH_W-1:0] second_end_month;
    logic [DAY_W-1:0]   second_end_day;
  } dpod_in_t;

  typedef struct packed {
    logic [COUNT_W-1:0] overlap_days;
    logic               bad_date;
  } dpod_out_t;

  // days before the month in a year that starts in march
  function automatic logic [MOFF_W-1:0] month_offset(input logic [MONTH_W-1:0] m);
    logic [MOFF_W-1:0] r;
    unique case (m)
      4'd3:    r = 9'd0;
      4'd4:    r = 9'd31;
      4'd5:    r = 9'd61;
      4'd6:    r = 9'd92;
      4'd7:    r = 9'd122;
      4'd8:    r = 9'd153;
      4'd9:    r = 9'd184;
      4'd10:   r = 9'd214;
      4'd11:   r = 9'd245;
      4'd12:   r = 9'd275;
      4'd1:    r = 9'd306;
      4'd2:    r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  // length of a month, zero for a month that does not exist
  function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
    logic [DAY_W-1:0] r;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    r = 5'd30;
      4'd2:    r = leap ? 5'd29 : 5'd28;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/date_period_overlap_days.sv
// date_period_overlap_days: each start transfer yields one out_valid strobe
// throughput one query per cycle; busy is tied low, each query enters the pipeline at once
// five register stages: year split and multiplies, day-number parts, day numbers,
// interval bounds, output register; the receiver cannot stall, results are never held
// synchronous active-low reset clears all stage valid bits, payload registers keep no reset
// depends on rtl/dpod_pkg.sv
`default_nettype none

module date_period_overlap_days import dpod_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  output logic           busy,
  input  wire dpod_in_t  in_item,
  output logic           out_valid,
  output dpod_out_t      out_item
);

  // ---------------------------------------------------------------------------
  // the four dates as lanes: 0 first start, 1 first end, 2 second start,
  // 3 second end
  // ---------------------------------------------------------------------------
  logic [YEAR_W-1:0]  y_in [NDATES];
  logic [MONTH_W-1:0] m_in [NDATES];
  logic [DAY_W-1:0]   d_in [NDATES];

  assign y_in[0] = in_item.first_start_year;
  assign m_in[0] = in_item.first_start_month;
  assign d_in[0] = in_item.first_start_day;
  assign y_in[1] = in_item.first_end_year;
  assign m_in[1] = in_item.first_end_month;
  assign d_in[1] = in_item.first_end_day;
  assign y_in[2] = in_item.second_start_year;
  assign m_in[2] = in_item.second_start_month;
  assign d_in[2] = in_item.second_start_day;
  assign y_in[3] = in_item.second_end_year;
  assign m_in[3] = in_item.second_end_month;
  assign d_in[3] = in_item.second_end_day;

  // every query is independent, so the pipeline never pushes back
  assign busy = 1'b0;

  logic accept;
  assign accept = start & ~busy;

  // ---------------------------------------------------------------------------
  // stage 1: bias the year (march-based years, january and february count
  // with the year before), then the three constant multiplies:
  // 365 * year, year / 100 for the day number and calendar year / 100 for
  // the leap test
  // ---------------------------------------------------------------------------
  logic               s1_valid_r;
  logic [YEAR_W-1:0]  s1_y_r      [NDATES];
  logic [MONTH_W-1:0] s1_m_r      [NDATES];
  logic [DAY_W-1:0]   s1_d_r      [NDATES];
  logic [BYEAR_W-1:0] s1_yy_r     [NDATES];
  logic [QUOT_W-1:0]  s1_yyq_r    [NDATES];
  logic [QUOT_W-1:0]  s1_yq_r     [NDATES];
  logic [DAYNUM_W-1:0] s1_y365_r  [NDATES];

  logic [BYEAR_W-1:0]  s1_yy_nxt   [NDATES];
  logic [QUOT_W-1:0]   s1_yyq_nxt  [NDATES];
  logic [QUOT_W-1:0]   s1_yq_nxt   [NDATES];
  logic [DAYNUM_W-1:0] s1_y365_nxt [NDATES];
  logic [27:0]         yy_prod     [NDATES];
  logic [26:0]         y_prod      [NDATES];
  logic [23:0]         y365_prod   [NDATES];

  always_comb begin
    for (int i = 0; i < NDATES; i++) begin
      s1_yy_nxt[i] = BYEAR_W'(y_in[i]) + YEAR_BIAS
                   - ((m_in[i] <= 4'd2) ? 15'd1 : 15'd0);
      yy_prod[i]     = 28'(s1_yy_nxt[i]) * 28'(RECIP_100);
      y_prod[i]      = 27'(y_in[i]) * 27'(RECIP_100);
      y365_prod[i]   = 24'(s1_yy_nxt[i]) * 24'(DAYS_YEAR);
      s1_yyq_nxt[i]  = yy_prod[i][RECIP_SHIFT +: QUOT_W];
      s1_yq_nxt[i]   = y_prod[i][RECIP_SHIFT +: QUOT_W];
      s1_y365_nxt[i] = y365_prod[i][DAYNUM_W-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // stage 2: leap test and range checks; day number split into a wide part
  // (365 * yy + yy/4 - yy/100) and a narrow part (yy/400 + month + day)
  // ---------------------------------------------------------------------------
  logic                s2_valid_r;
  logic [NDATES-1:0]   s2_ok_r;
  logic [DAYNUM_W-1:0] s2_wide_r   [NDATES];
  logic [PART_W-1:0]   s2_narrow_r [NDATES];

  logic [NDATES-1:0]   s2_ok_nxt;
  logic [DAYNUM_W-1:0] s2_wide_nxt   [NDATES];
  logic [PART_W-1:0]   s2_narrow_nxt [NDATES];
  logic [YEAR_W-1:0]   y_rem   [NDATES];
  logic [NDATES-1:0]   is_leap;
  logic [DAY_W-1:0]    mlen    [NDATES];

  always_comb begin
    for (int i = 0; i < NDATES; i++) begin
      // year mod 100 via the registered quotient
      y_rem[i]   = s1_y_r[i] - YEAR_W'(15'(s1_yq_r[i]) * 15'(HUNDRED));
      // divisible by 4, and either not by 100 or also by 400
      is_leap[i] = (s1_y_r[i][1:0] == 2'd0)
                 && ((y_rem[i] != '0) || (s1_yq_r[i][1:0] == 2'd0));
      mlen[i]    = month_days(s1_m_r[i], is_leap[i]);
      // month_days gives zero for a month outside the calendar
      s2_ok_nxt[i] = (mlen[i] != '0) && (s1_d_r[i] != '0) && (s1_d_r[i] <= mlen[i]);
      s2_wide_nxt[i] = s1_y365_r[i] + DAYNUM_W'(s1_yy_r[i] >> 2)
                     - DAYNUM_W'(s1_yyq_r[i]);
      s2_narrow_nxt[i] = PART_W'(s1_yyq_r[i] >> 2) + PART_W'(month_offset(s1_m_r[i]))
                       + PART_W'(s1_d_r[i]);
    end
  end

  // ---------------------------------------------------------------------------
  // stage 3: full day numbers and the combined date check
  // ---------------------------------------------------------------------------
  logic                s3_valid_r;
  logic                s3_bad_r;
  logic [DAYNUM_W-1:0] s3_dn_r [NDATES];

  logic [DAYNUM_W-1:0] s3_dn_nxt [NDATES];

  always_comb begin
    for (int i = 0; i < NDATES; i++) begin
      s3_dn_nxt[i] = s2_wide_r[i] + DAYNUM_W'(s2_narrow_r[i]);
    end
  end

  // ---------------------------------------------------------------------------
  // stage 4: intersection bounds, later start and earlier end
  // ---------------------------------------------------------------------------
  logic                s4_valid_r;
  logic                s4_bad_r;
  logic [DAYNUM_W-1:0] s4_lo_r;
  logic [DAYNUM_W-1:0] s4_hi_r;

  logic [DAYNUM_W-1:0] s4_lo_nxt;
  logic [DAYNUM_W-1:0] s4_hi_nxt;

  assign s4_lo_nxt = (s3_dn_r[0] > s3_dn_r[2]) ? s3_dn_r[0] : s3_dn_r[2];
  assign s4_hi_nxt = (s3_dn_r[1] < s3_dn_r[3]) ? s3_dn_r[1] : s3_dn_r[3];

  // ---------------------------------------------------------------------------
  // stage 5: inclusive length, zero when empty or a date is bad, saturated
  // to the field width
  // ---------------------------------------------------------------------------
  logic      out_valid_r;
  dpod_out_t out_item_r;
  dpod_out_t out_item_nxt;
  logic [DAYNUM_W-1:0] span;

  assign span = s4_hi_r - s4_lo_r;

  always_comb begin
    out_item_nxt.bad_date = s4_bad_r;
    if (s4_bad_r || (s4_hi_r < s4_lo_r)) begin
      out_item_nxt.overlap_days = '0;
    end else if (span >= DAYNUM_W'(OVERLAP_MAX)) begin
      out_item_nxt.overlap_days = OVERLAP_MAX;
    end else begin
      out_item_nxt.overlap_days = span[COUNT_W-1:0] + COUNT_W'(1);
    end
  end

  // ---------------------------------------------------------------------------
  // valid bits, the only state that reset clears
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      s4_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= accept;
      s2_valid_r  <= s1_valid_r;
      s3_valid_r  <= s2_valid_r;
      s4_valid_r  <= s3_valid_r;
      out_valid_r <= s4_valid_r;
    end
  end

  // payload registers, loaded only behind a valid item
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < NDATES; i++) begin
        s1_y_r[i]    <= y_in[i];
        s1_m_r[i]    <= m_in[i];
        s1_d_r[i]    <= d_in[i];
        s1_yy_r[i]   <= s1_yy_nxt[i];
        s1_yyq_r[i]  <= s1_yyq_nxt[i];
        s1_yq_r[i]   <= s1_yq_nxt[i];
        s1_y365_r[i] <= s1_y365_nxt[i];
      end
    end
    if (s1_valid_r) begin
      s2_ok_r <= s2_ok_nxt;
      for (int i = 0; i < NDATES; i++) begin
        s2_wide_r[i]   <= s2_wide_nxt[i];
        s2_narrow_r[i] <= s2_narrow_nxt[i];
      end
    end
    if (s2_valid_r) begin
      s3_bad_r <= ~(&s2_ok_r);
      for (int i = 0; i < NDATES; i++) begin
        s3_dn_r[i] <= s3_dn_nxt[i];
      end
    end
    if (s3_valid_r) begin
      s4_bad_r <= s3_bad_r;
      s4_lo_r  <= s4_lo_nxt;
      s4_hi_r  <= s4_hi_nxt;
    end
    if (s4_valid_r) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  // every strobe comes from an earlier start transfer
  a_strobe_has_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, 5))
    else $error("result strobe without a matching start transfer");

  // every start transfer yields a strobe at the pipeline output
  a_transfer_completes: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##5 out_valid)
    else $error("start transfer lost in the pipeline");

  // a bad date always reports an empty overlap
  a_bad_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.bad_date) |-> (out_item.overlap_days == '0))
    else $error("bad date with a non-zero overlap count");

endmodule

`default_nettype wire
